### src/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared constants and types of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int DefValueWidth = 32;
  localparam int FieldWidth    = 32;
  localparam int DenWidth      = 31;

  typedef enum logic [2:0] {
    FUNC_NORM = 3'd0,
    FUNC_ADD  = 3'd1,
    FUNC_SUB  = 3'd2,
    FUNC_MUL  = 3'd3,
    FUNC_DIV  = 3'd4,
    FUNC_LT   = 3'd5,
    FUNC_EQ   = 3'd6,
    FUNC_NOP  = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]            func;
    logic [FieldWidth-1:0] a_num;
    logic [FieldWidth-1:0] a_den;
    logic [FieldWidth-1:0] b_num;
    logic [FieldWidth-1:0] b_den;
  } req_t;

  typedef struct packed {
    logic [FieldWidth-1:0] res_num;
    logic [DenWidth-1:0]   res_den;
    logic                  cmp_true;
    logic [1:0]            status;
  } rsp_t;

endpackage

### src/rau_if.sv
// ----------------------------------------------------------------------------
// rau_req_if / rau_rsp_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
interface rau_req_if;
  logic          valid;
  logic          ready;
  rau_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rau_rsp_if;
  logic          valid;
  logic          ready;
  rau_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/rau_gcd.sv
// ----------------------------------------------------------------------------
// rau_gcd
// Binary GCD of two non-zero magnitudes followed by restoring division of
// both by the GCD, one step per cycle.
// ----------------------------------------------------------------------------
module rau_gcd #(
  parameter int MagWidth = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [MagWidth-1:0] x,
  input  logic [MagWidth-1:0] y,
  output logic                done,
  output logic [MagWidth-1:0] xq,
  output logic [MagWidth-1:0] yq
);

  localparam int CntWidth = $clog2(MagWidth + 1);

  typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_ODD, S_SUB, S_DIVX, S_DIVY, S_DONE} state_t;

  state_t              state;
  logic [MagWidth-1:0] u, v, g, ox, oy, rem, quo, dvd;
  logic [CntWidth-1:0] k, cnt;
  logic [MagWidth:0]   trial;

  assign done  = (state == S_DONE);
  assign trial = {rem, dvd[MagWidth-1]} - {1'b0, g};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            u     <= x;
            v     <= y;
            ox    <= x;
            oy    <= y;
            k     <= '0;
            state <= S_SHIFT;
          end
        end
        // Remove common factors of two, counting them in k.
        S_SHIFT: begin
          if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + 1'b1;
          end else begin
            state <= S_ODD;
          end
        end
        S_ODD: begin
          if (!u[0]) u <= u >> 1;
          else if (!v[0]) v <= v >> 1;
          else state <= S_SUB;
        end
        S_SUB: begin
          if (u == v) begin
            g     <= u << k;
            rem   <= '0;
            dvd   <= ox;
            cnt   <= CntWidth'(MagWidth);
            state <= S_DIVX;
          end else if (u > v) begin
            u     <= u - v;
            state <= S_ODD;
          end else begin
            v     <= v - u;
            state <= S_ODD;
          end
        end
        S_DIVX, S_DIVY: begin
          if (cnt == '0) begin
            if (state == S_DIVX) begin
              xq    <= quo;
              rem   <= '0;
              dvd   <= oy;
              cnt   <= CntWidth'(MagWidth);
              state <= S_DIVY;
            end else begin
              yq    <= quo;
              state <= S_DONE;
            end
          end else begin
            // Remainder stays below g, so one extra bit suffices.
            if (!trial[MagWidth]) begin
              rem <= trial[MagWidth-1:0];
              quo <= {quo[MagWidth-2:0], 1'b1};
            end else begin
              rem <= {rem[MagWidth-2:0], dvd[MagWidth-1]};
              quo <= {quo[MagWidth-2:0], 1'b0};
            end
            dvd <= dvd << 1;
            cnt <= cnt - 1'b1;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies, divides, compares and normalises fractions,
// reducing results by their GCD.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload
//  req      in   func, a_num, a_den, b_num, b_den
//  rsp      out  res_num, res_den, cmp_true, status
//
//  One item at a time. Arithmetic results pass through the products, the binary
//  GCD loop and the two bit-serial divisions by the GCD. Errors go straight to
//  the result beat; comparisons and zero results skip the GCD reduction.
//  Products are formed in turn on one multiplier, 32x32 at the default width.
//  req.ready is low from acceptance until the result beat is taken.
//  Synchronous reset returns the unit to idle.
module rational_arithmetic_unit #(
  parameter int VALUE_WIDTH = rau_pkg::DefValueWidth
) (
  input logic       clk,
  input logic       rst,
  rau_req_if.sink   req,
  rau_rsp_if.source rsp
);

  localparam int W  = VALUE_WIDTH;
  localparam int MW = 2 * W;
  localparam int FW = rau_pkg::FieldWidth;
  localparam int DW = rau_pkg::DenWidth;

  typedef enum logic [2:0] {S_IDLE, S_M0, S_M1, S_M2, S_SUM, S_RED, S_OUT} state_t;

  state_t              state;
  logic [2:0]          func;
  logic [W-1:0]        an, ad, bn, bd;
  logic [MW-1:0]       p0, p1, nmag, dmag;
  logic                p0n, p1n, nneg, dneg;
  logic                p1s, is_cmp;
  logic [W-1:0]        mx, my;
  logic                mxn, myn;
  logic [MW-1:0]       prod;
  logic                gstart, gdone, launched;
  logic [MW-1:0]       gxq, gyq;
  logic                rneg;
  logic [MW-1:0]       lim;
  rau_pkg::rsp_t       out;

  function automatic logic [W-1:0] absv(input logic [W-1:0] v);
    absv = v[W-1] ? W'(-v) : v;
  endfunction

  assign lim  = (MW'(1) << (W - 1)) - MW'(1);
  assign prod = MW'(mx) * MW'(my);

  // Multiplier operand selection per step.
  always_comb begin
    mx = absv(an); my = absv(bd); mxn = an[W-1]; myn = bd[W-1];
    unique case (state)
      S_M0: begin
        if (func == rau_pkg::FUNC_MUL) begin
          my = absv(bn); myn = bn[W-1];
        end else if (func == rau_pkg::FUNC_NORM) begin
          my = W'(1); myn = 1'b0;
        end
      end
      S_M1: begin
        mx = absv(bn); mxn = bn[W-1]; my = absv(ad); myn = ad[W-1];
      end
      S_M2: begin
        mx = absv(ad); mxn = ad[W-1];
        if (func == rau_pkg::FUNC_DIV) begin
          my = absv(bn); myn = bn[W-1];
        end else if (func == rau_pkg::FUNC_NORM) begin
          my = W'(1); myn = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Addition flips the sign back for the second product.
  assign p1s    = p1n ^ (func == rau_pkg::FUNC_ADD);
  assign is_cmp = (func == rau_pkg::FUNC_LT) || (func == rau_pkg::FUNC_EQ);
  assign rneg   = nneg != dneg;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.data  = out;

  rau_gcd #(.MagWidth(MW)) u_gcd (
    .clk(clk), .rst(rst), .start(gstart), .x(nmag), .y(dmag),
    .done(gdone), .xq(gxq), .yq(gyq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      gstart   <= 1'b0;
      launched <= 1'b0;
    end else begin
      // The GCD unit is started once per item; its start pulse is registered from the first reduction cycle.
      gstart <= (state == S_RED) && !launched && !is_cmp && (nmag != '0);
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            func         <= req.data.func;
            an           <= req.data.a_num[W-1:0];
            ad           <= req.data.a_den[W-1:0];
            bn           <= req.data.b_num[W-1:0];
            bd           <= req.data.b_den[W-1:0];
            out.res_num  <= '0;
            out.res_den  <= DW'(1);
            out.cmp_true <= 1'b0;
            if (req.data.func == rau_pkg::FUNC_NOP) begin
              out.status <= rau_pkg::ST_OK;
              state      <= S_OUT;
            end else if (req.data.a_den[W-1:0] == '0 ||
                         (req.data.func != rau_pkg::FUNC_NORM &&
                          req.data.b_den[W-1:0] == '0)) begin
              out.status <= rau_pkg::ST_ZERO_DEN;
              state      <= S_OUT;
            end else if (req.data.func == rau_pkg::FUNC_DIV &&
                         req.data.b_num[W-1:0] == '0) begin
              out.status <= rau_pkg::ST_DIV_ZERO;
              state      <= S_OUT;
            end else begin
              out.status <= rau_pkg::ST_OK;
              state      <= S_M0;
            end
          end
        end
        S_M0: begin
          p0    <= prod;
          p0n   <= (prod != '0) && (mxn != myn);
          state <= (func == rau_pkg::FUNC_MUL || func == rau_pkg::FUNC_DIV ||
                    func == rau_pkg::FUNC_NORM) ? S_M2 : S_M1;
        end
        S_M1: begin
          p1    <= prod;
          p1n   <= (prod != '0) && (mxn == myn);   // negated second product
          state <= S_M2;
        end
        S_M2: begin
          dmag  <= prod;
          dneg  <= mxn != myn;
          state <= S_SUM;
        end
        S_SUM: begin
          if (func == rau_pkg::FUNC_ADD || func == rau_pkg::FUNC_SUB || is_cmp) begin
            if (p0n == p1s) begin
              nmag <= p0 + p1;
              nneg <= p0n;
            end else if (p0 > p1) begin
              nmag <= p0 - p1;
              nneg <= p0n;
            end else if (p0 == p1) begin
              nmag <= '0;
              nneg <= 1'b0;
            end else begin
              nmag <= p1 - p0;
              nneg <= p1s;
            end
          end else begin
            nmag <= p0;
            nneg <= p0n;
          end
          state <= S_RED;
        end
        S_RED: begin
          if (is_cmp) begin
            out.cmp_true <= (func == rau_pkg::FUNC_EQ) ? (nmag == '0)
                                                       : (nmag != '0 && rneg);
            state <= S_OUT;
          end else if (nmag == '0) begin
            state <= S_OUT;
          end else if (launched && gdone) begin
            if (gyq > lim || gxq > (rneg ? lim + MW'(1) : lim)) begin
              out.status <= rau_pkg::ST_OVERFLOW;
            end else begin
              out.res_num <= FW'($signed(rneg ? MW'(-gxq) : gxq));
              out.res_den <= DW'(gyq);
            end
            state <= S_OUT;
          end else if (!launched) begin
            launched <= 1'b1;
          end
        end
        S_OUT: begin
          launched <= 1'b0;
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !rsp.valid) else $error("ready while result pending");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && out.status != rau_pkg::ST_OK) |->
      (out.res_num == '0 && out.res_den == DW'(1)))
    else $error("error result not 0/1");
  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> out.res_den != '0) else $error("zero result denominator");

endmodule
